FILE: hdl/pip_pkg.sv
// pip_pkg: shared constants, codes and transaction types for the point in
// polygon test core; no dependencies
`default_nettype none

package pip_pkg;

  localparam int MAX_EDGES   = 64;
  localparam int COORD_WIDTH = 24;
  localparam int LEN_W       = 23;

  localparam int IDX_W  = $clog2(MAX_EDGES);
  localparam int CNT_W  = $clog2(MAX_EDGES + 1);
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int MUL_W  = (DIFF_W > LEN_W + 1) ? DIFF_W : LEN_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic [LEN_W-1:0] RAY_LENGTH_RESET = LEN_W'(100000);

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic signed [COORD_WIDTH-1:0] edge_start_x;
    logic signed [COORD_WIDTH-1:0] edge_start_y;
    logic signed [COORD_WIDTH-1:0] edge_end_x;
    logic signed [COORD_WIDTH-1:0] edge_end_y;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
  } pip_in_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] crossings;
    logic [CNT_W-1:0] edges_held;
    logic             status;
  } pip_out_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
  } pip_edge_t;

  localparam int EDGE_W = $bits(pip_edge_t);

endpackage

`default_nettype wire

FILE: hdl/pip_ram.sv
// pip_ram: generic single write port, single read port ram with registered read
// no package dependencies
`default_nettype none

module pip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/point_in_polygon_test_core.sv
// point_in_polygon_test_core: edge table plus ray crossing query sequencer
// built around one shared signed multiplier; uses pip_pkg and pip_ram
//
// clear, append and unused requests: result strobe in the cycle after accept,
// busy stays low. query: strobe registered from the last edge's S_CMP state (in
// the cycle after accept when the table is empty), busy high until the strobe.
// each edge costs a table read and three products through the one multiplier.
// the receiver cannot stall. synchronous reset empties the table and sets
// ray_length to 100000; table contents stay undefined until written.
`default_nettype none

module point_in_polygon_test_core
  import pip_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire pip_in_t          in_data,
  output logic                  out_valid,
  output pip_out_t              out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_M0, S_M1, S_M2, S_CMP
  } state_t;

  state_t                    state_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [IDX_W-1:0]          idx_r;
  logic [CNT_W-1:0]          hits_r;
  logic [LEN_W-1:0]          len_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  pip_out_t                  out_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic signed [DIFF_W-1:0]  dx_r, dy_r, ox_r, oy_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      ehit_r;

  logic                      accept;
  logic                      last_edge;
  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_raddr;
  pip_edge_t                 ram_wdata, ram_rdata;
  logic [EDGE_W-1:0]         ram_rdata_bits;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DIFF_W:0]    oy_dy;
  logic                      ehit;
  logic signed [ACC_W-1:0]   den;
  logic                      ray_ok;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = start && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign last_edge = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  always_comb begin
    out_valid_nxt = 1'b0;
    if (accept) begin
      out_valid_nxt = (in_data.req_type != REQ_QUERY) || (cnt_r == '0);
    end else if ((state_r == S_CMP) && last_edge) begin
      out_valid_nxt = 1'b1;
    end
  end

  // edge table
  assign ram_we    = accept && (in_data.req_type == REQ_APPEND) &&
                     (cnt_r < CNT_W'(MAX_EDGES));
  assign ram_wdata = '{ax: in_data.edge_start_x, ay: in_data.edge_start_y,
                       bx: in_data.edge_end_x,   by: in_data.edge_end_y};

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (accept && (in_data.req_type == REQ_QUERY)) begin
      ram_re = 1'b1;
    end else if ((state_r == S_CMP) && !last_edge) begin
      ram_re    = 1'b1;
      ram_raddr = idx_r + IDX_W'(1);
    end
  end

  pip_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_bits)
  );

  assign ram_rdata = pip_edge_t'(ram_rdata_bits);

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_M0: begin
        mul_a = MUL_W'(dy_r);
        mul_b = MUL_W'(ox_r);
      end
      S_M1: begin
        mul_a = MUL_W'(dx_r);
        mul_b = MUL_W'(oy_r);
      end
      default: begin
        mul_a = MUL_W'($signed({1'b0, len_r}));
        mul_b = MUL_W'(dy_r);
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // edge parameter test, scaled by the positive ray length
  assign oy_dy = (DIFF_W + 1)'(oy_r) + (DIFF_W + 1)'(dy_r);
  always_comb begin
    if (dy_r == '0) begin
      ehit = 1'b0;
    end else if (!dy_r[DIFF_W-1]) begin
      ehit = (oy_r <= 0) && (oy_dy >= 0);
    end else begin
      ehit = (oy_r >= 0) && (oy_dy <= 0);
    end
  end

  // ray parameter test against the cross product denominator
  assign den = -ACC_W'(prod_r);
  always_comb begin
    if (den == '0) begin
      ray_ok = 1'b0;
    end else if (!den[ACC_W-1]) begin
      ray_ok = (acc_r >= 0) && (acc_r <= den);
    end else begin
      ray_ok = (acc_r >= den) && (acc_r <= 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      len_r       <= RAY_LENGTH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_data.req_type)
              REQ_CLEAR: begin
                cnt_r <= '0;
                out_r <= '{inside_res: 1'b0, crossings: '0, edges_held: '0,
                           status: STATUS_OK};
              end
              REQ_APPEND: begin
                if (ram_we) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                  out_r <= '{inside_res: 1'b0, crossings: '0,
                             edges_held: cnt_r + CNT_W'(1), status: STATUS_OK};
                end else begin
                  out_r <= '{inside_res: 1'b0, crossings: '0,
                             edges_held: cnt_r, status: STATUS_FULL};
                end
              end
              REQ_QUERY: begin
                if (cnt_r != '0) begin
                  state_r <= S_DIFF;
                end
                out_r  <= '{inside_res: 1'b0, crossings: '0, edges_held: cnt_r,
                            status: STATUS_OK};
                idx_r  <= '0;
                hits_r <= '0;
                px_r   <= in_data.point_x;
                py_r   <= in_data.point_y;
              end
              default: begin
                out_r <= '{inside_res: 1'b0, crossings: '0, edges_held: cnt_r,
                           status: STATUS_OK};
              end
            endcase
          end
        end
        S_DIFF: begin
          dx_r    <= DIFF_W'(ram_rdata.bx) - DIFF_W'(ram_rdata.ax);
          dy_r    <= DIFF_W'(ram_rdata.by) - DIFF_W'(ram_rdata.ay);
          ox_r    <= DIFF_W'(ram_rdata.ax) - DIFF_W'(px_r);
          oy_r    <= DIFF_W'(ram_rdata.ay) - DIFF_W'(py_r);
          state_r <= S_M0;
        end
        S_M0: begin
          prod_r  <= prod;
          ehit_r  <= ehit;
          state_r <= S_M1;
        end
        S_M1: begin
          acc_r   <= -ACC_W'(prod_r);
          prod_r  <= prod;
          state_r <= S_M2;
        end
        S_M2: begin
          acc_r   <= acc_r + ACC_W'(prod_r);
          prod_r  <= prod;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (last_edge) begin
            out_r.inside_res <= hits_r[0] ^ (ehit_r && ray_ok);
            out_r.crossings  <= hits_r + CNT_W'(ehit_r && ray_ok);
            out_r.edges_held <= cnt_r;
            out_r.status     <= STATUS_OK;
            state_r          <= S_IDLE;
          end else begin
            hits_r  <= hits_r + CNT_W'(ehit_r && ray_ok);
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_DIFF;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy && out_valid))
    else $error("result strobe while busy");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_EDGES))
    else $error("edge count beyond table depth");

  a_short_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.req_type != REQ_QUERY)) |=> out_valid)
    else $error("missing result for non-query transaction");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STATUS_FULL)) |->
      (out_data.edges_held == CNT_W'(MAX_EDGES)))
    else $error("full status with table not full");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for point_in_polygon_test_core, edge table loads and
// ray crossing queries checked against a behavioral model kept in this file
// depends on pip_pkg and the core rtl only
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  pip_in_t          in_data = '0;
  logic             cfg_valid = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic             busy;
  logic             out_valid;
  logic             cfg_ready;
  pip_out_t         out_data;

  point_in_polygon_test_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pip_edge_t        edge_store [MAX_EDGES];
  int               edge_total = 0;
  logic [LEN_W-1:0] ray_len = RAY_LENGTH_RESET;
  pip_out_t         answers_due [$];
  int               fail_count = 0;
  int               items_issued = 0;
  bit               steady = 1'b0;

  function automatic bit in_closed_unit(longint num, longint den);
    if (den > 0) begin
      return num >= 0 && num <= den;
    end else if (den < 0) begin
      return num >= den && num <= 0;
    end
    return 1'b0;
  endfunction

  function automatic bit ray_meets_edge(pip_edge_t e, longint px, longint py);
    longint len, dx, dy, ox, oy, den, ray_num, seg_num;
    len = longint'(ray_len);
    dx = longint'(e.bx) - longint'(e.ax);
    dy = longint'(e.by) - longint'(e.ay);
    ox = longint'(e.ax) - px;
    oy = longint'(e.ay) - py;
    den = -(len * dy);
    ray_num = dx * oy - dy * ox;
    seg_num = len * oy;
    return in_closed_unit(ray_num, den) && in_closed_unit(seg_num, den);
  endfunction

  function automatic pip_out_t compute_answer(pip_in_t it);
    pip_out_t ans;
    int hits;
    ans = '0;
    hits = 0;
    ans.status = STATUS_OK;
    case (it.req_type)
      REQ_CLEAR: begin
        edge_total = 0;
      end
      REQ_APPEND: begin
        if (edge_total >= MAX_EDGES) begin
          ans.status = STATUS_FULL;
        end else begin
          edge_store[edge_total].ax = it.edge_start_x;
          edge_store[edge_total].ay = it.edge_start_y;
          edge_store[edge_total].bx = it.edge_end_x;
          edge_store[edge_total].by = it.edge_end_y;
          edge_total++;
        end
      end
      REQ_QUERY: begin
        for (int i = 0; i < edge_total; i++) begin
          if (ray_meets_edge(edge_store[i], longint'(it.point_x), longint'(it.point_y)))
            hits++;
        end
        ans.crossings = CNT_W'(hits);
        ans.inside_res = hits[0];
      end
      default: ;
    endcase
    ans.edges_held = CNT_W'(edge_total);
    return ans;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      pip_out_t want;
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = answers_due.pop_front();
        if (out_data.inside_res !== want.inside_res)
          report_mismatch("inside_res", out_data.inside_res, want.inside_res);
        if (out_data.crossings !== want.crossings)
          report_mismatch("crossings", out_data.crossings, want.crossings);
        if (out_data.edges_held !== want.edges_held)
          report_mismatch("edges_held", out_data.edges_held, want.edges_held);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
  end

  task automatic issue(input pip_in_t item);
    if (!steady) begin
      while ($urandom_range(99) < 13) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    answers_due.insert(answers_due.size(), compute_answer(item));
    items_issued++;
  endtask

  task automatic idle_until_drained();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_ray_length(input logic [LEN_W-1:0] value);
    idle_until_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ray_len = value;
  endtask

  function automatic pip_in_t random_item();
    pip_in_t it;
    it.req_type = 2'($urandom_range(3));
    it.edge_start_x = COORD_WIDTH'($urandom());
    it.edge_start_y = COORD_WIDTH'($urandom());
    it.edge_end_x = COORD_WIDTH'($urandom());
    it.edge_end_y = COORD_WIDTH'($urandom());
    it.point_x = COORD_WIDTH'($urandom());
    it.point_y = COORD_WIDTH'($urandom());
    return it;
  endfunction

  function automatic pip_in_t bare_item(logic [1:0] req);
    pip_in_t it;
    it = random_item();
    it.req_type = req;
    return it;
  endfunction

  function automatic pip_in_t edge_item(int ax, int ay, int bx, int by);
    pip_in_t it;
    it = bare_item(REQ_APPEND);
    it.edge_start_x = COORD_WIDTH'(ax);
    it.edge_start_y = COORD_WIDTH'(ay);
    it.edge_end_x = COORD_WIDTH'(bx);
    it.edge_end_y = COORD_WIDTH'(by);
    return it;
  endfunction

  function automatic pip_in_t query_item(int px, int py);
    pip_in_t it;
    it = bare_item(REQ_QUERY);
    it.point_x = COORD_WIDTH'(px);
    it.point_y = COORD_WIDTH'(py);
    return it;
  endfunction

  function automatic int near(int c, int r);
    int v;
    v = c - r + int'($urandom_range(2 * r));
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v;
  endfunction

  task automatic test_corner_items();
    issue(query_item(0, 0));
    issue(bare_item(REQ_UNUSED));
    issue(edge_item(-100, -100, 100, -100));
    issue(edge_item(100, -100, 100, 100));
    issue(edge_item(100, 100, -100, 100));
    issue(edge_item(-100, 100, -100, -100));
    issue(query_item(0, 0));
    issue(query_item(-100, -100));
    issue(query_item(200, 0));
    issue(edge_item(5, 5, 5, 5));
    issue(query_item(0, 5));
    issue(bare_item(REQ_CLEAR));
    issue(edge_item(0, -5, 0, 5));
    issue(query_item(-10, 0));
    issue(edge_item(CMIN, CMIN, CMAX, CMAX));
    issue(edge_item(CMAX, CMIN, CMIN, CMAX));
    issue(query_item(CMIN, CMAX));
    issue(query_item(CMAX, CMIN));
    issue(query_item(CMIN, CMIN));
    issue(query_item(CMIN, 0));
    issue(edge_item(CMAX, CMAX, CMAX, CMAX));
    issue('1);
  endtask

  task automatic test_ray_extremes();
    write_ray_length('0);
    issue(query_item(-10, 0));
    issue(query_item(0, 0));
    write_ray_length(LEN_W'(1));
    issue(query_item(-1, 0));
    issue(query_item(-2, 0));
    issue(query_item(-1, -5));
    write_ray_length(LEN_MAX);
    issue(query_item(CMIN, 0));
    issue(query_item(CMIN, CMAX));
    issue(query_item(-1, 1));
    write_ray_length(RAY_LENGTH_RESET);
  endtask

  task automatic test_full_table();
    issue(bare_item(REQ_CLEAR));
    for (int i = 0; i < MAX_EDGES; i++) begin
      issue(edge_item(near(0, 1000), near(0, 1000), near(0, 1000), near(0, 1000)));
    end
    issue(edge_item(1, 2, 3, 4));
    issue(query_item(near(-500, 500), near(0, 1000)));
    issue(bare_item(REQ_UNUSED));
    issue(edge_item(-7, -7, 7, 7));
    issue(bare_item(REQ_CLEAR));
  endtask

  task automatic polygon_round(int cx, int cy, int r, int n_edges, int n_queries);
    int vx [MAX_EDGES];
    int vy [MAX_EDGES];
    int k;
    issue(bare_item(REQ_CLEAR));
    for (int i = 0; i < n_edges; i++) begin
      vx[i] = near(cx, r);
      vy[i] = near(cy, r);
    end
    for (int i = 0; i < n_edges; i++) begin
      k = (i + 1) % n_edges;
      issue(edge_item(vx[i], vy[i], vx[k], vy[k]));
    end
    for (int q = 0; q < n_queries; q++) begin
      k = $urandom_range(n_edges - 1);
      if ($urandom_range(3) == 0)
        issue(query_item(near(cx, 2 * r), vy[k]));
      else
        issue(query_item(near(cx, 2 * r), near(cy, 2 * r)));
    end
  endtask

  task automatic test_random_polygons();
    int r, cx, cy, n_edges, pick;
    while (items_issued < 950) begin
      steady = items_issued >= 350 && items_issued < 500;
      pick = $urandom_range(2);
      r = (pick == 0) ? $urandom_range(40, 1) :
          (pick == 1) ? $urandom_range(5000, 1) : $urandom_range(1 << 20, 1);
      cx = near(0, CMAX - 2 * r);
      cy = near(0, CMAX - 2 * r);
      if ($urandom_range(5) == 0) begin
        pick = $urandom_range(9);
        if (pick == 0)
          write_ray_length(LEN_W'(1));
        else if (pick == 1)
          write_ray_length(LEN_MAX);
        else if (pick == 2)
          write_ray_length(LEN_W'($urandom_range(CMAX, 1)));
        else
          write_ray_length(LEN_W'($urandom_range(4 * r, 1)));
      end
      n_edges = ($urandom_range(9) == 0) ? $urandom_range(MAX_EDGES, 20) :
                $urandom_range(12, 3);
      polygon_round(cx, cy, r, n_edges, $urandom_range(10, 3));
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(4, 1)) issue(random_item());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_items();
    test_ray_extremes();
    test_full_table();
    test_random_polygons();
    idle_until_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
